[design/lbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the block buffer cache tag engine.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int RANK_W    = SLOT_W;

  localparam int OP_W      = 2;
  localparam int DEV_W     = 8;
  localparam int BLOCK_W   = 32;
  localparam int SLOT_FW   = 5;
  localparam int STATUS_W  = 2;
  localparam int TAG_W     = DEV_W + BLOCK_W;
  localparam int CNT_W     = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_COUNT_ERR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_FETCH,
    CS_SCAN,
    CS_LAST,
    CS_DECIDE
  } ctrl_state_e;

  typedef struct packed {
    op_e                op;
    logic [DEV_W-1:0]   dev;
    logic [BLOCK_W-1:0] block;
    logic [SLOT_FW-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_FW-1:0]  slot_out;
    logic                need_read;
    logic [STATUS_W-1:0] status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic search;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_is_read;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

[design/lbc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_ctrl
// Sequencer: accepts a request, walks the slots for reads, then commits.
// ----------------------------------------------------------------------------
module lbc_ctrl import lbc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != CS_IDLE);
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_FETCH;
        end
      end
      CS_FETCH: begin
        // first slot read is in flight for a lookup
        if (sts_i.req_is_read) begin
          cmd_o.step = 1'b1;
          state_d    = CS_SCAN;
        end else begin
          state_d = CS_DECIDE;
        end
      end
      CS_SCAN: begin
        cmd_o.step   = 1'b1;
        cmd_o.search = 1'b1;
        if (sts_i.idx_last) begin
          state_d = CS_LAST;
        end
      end
      CS_LAST: begin
        cmd_o.search = 1'b1;
        state_d      = CS_DECIDE;
      end
      CS_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/lbc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_dp
// Tag memory, counts, recency ranks, lookup registers and result register.
// ----------------------------------------------------------------------------
module lbc_dp import lbc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  logic    out_stall_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output logic    out_valid_o,
  output out_t    out_data_o
);

  in_t               req_q;
  logic [SLOT_W-1:0] idx_q;

  // slot state
  logic [TAG_W-1:0]     tag_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tag_w_q;
  logic [NUM_SLOTS-1:0] valid_q;
  logic [CNT_W-1:0]     cnt_q  [NUM_SLOTS];
  logic [RANK_W-1:0]    rank_q [NUM_SLOTS];

  // read stage of the slot at idx_q
  logic [TAG_W-1:0]  p_tag_q;
  logic              p_tagw_q;
  logic              p_valid_q;
  logic [CNT_W-1:0]  p_cnt_q;
  logic [RANK_W-1:0] p_rank_q;
  logic [SLOT_W-1:0] p_idx_q;

  // lookup results
  logic              hit_q, free_q;
  logic [SLOT_W-1:0] hs_q, fs_q;
  logic [RANK_W-1:0] hr_q, fr_q;
  logic [CNT_W-1:0]  hcnt_q;
  logic              hval_q;

  logic              out_valid_q;
  out_t              out_data_q;

  logic [TAG_W-1:0]  req_tag;
  logic [TAG_W-1:0]  p_tag_eff;
  logic              p_match;
  logic              p_free;
  logic              slot_ok;

  logic              wr_cnt, wr_tag, set_valid, touch;
  logic [SLOT_W-1:0] wr_addr;
  logic [CNT_W-1:0]  cnt_new;
  logic [SLOT_FW-1:0] res_slot;
  logic              res_nr;
  status_e           res_st;

  assign req_tag   = {req_q.dev, req_q.block};
  assign p_tag_eff = p_tagw_q ? p_tag_q : '0;
  assign p_match   = (p_tag_eff == req_tag);
  assign p_free    = (p_cnt_q == '0);
  assign slot_ok   = (int'(req_q.slot) < NUM_SLOTS);

  assign sts_o.req_is_read = (req_q.op == OP_READ);
  assign sts_o.idx_last    = (idx_q == SLOT_W'(NUM_SLOTS - 1));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // request and address register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
      idx_q <= (in_data_i.op == OP_READ) ? '0 : SLOT_W'(in_data_i.slot);
    end else if (cmd_i.step) begin
      idx_q <= idx_q + SLOT_W'(1);
    end
  end

  // tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_tag) begin
      tag_mem[wr_addr] <= req_tag;
    end
    p_tag_q <= tag_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    p_tagw_q  <= tag_w_q[idx_q];
    p_valid_q <= valid_q[idx_q];
    p_cnt_q   <= cnt_q[idx_q];
    p_rank_q  <= rank_q[idx_q];
    p_idx_q   <= idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_w_q <= '0;
      valid_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_q[i]  <= '0;
        rank_q[i] <= RANK_W'(i);
      end
    end else begin
      if (wr_tag) begin
        tag_w_q[wr_addr] <= 1'b1;
      end
      if (set_valid) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (wr_cnt) begin
        cnt_q[wr_addr] <= cnt_new;
      end
      // released slot becomes most recent, those above it move down
      if (touch) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (SLOT_W'(i) == wr_addr) begin
            rank_q[i] <= RANK_W'(NUM_SLOTS - 1);
          end else if (rank_q[i] > p_rank_q) begin
            rank_q[i] <= rank_q[i] - RANK_W'(1);
          end
        end
      end
    end
  end

  // lookup: most recent match, least recent free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.search) begin
      if (p_match && (!hit_q || p_rank_q > hr_q)) begin
        hit_q <= 1'b1;
      end
      if (p_free && (!free_q || p_rank_q < fr_q)) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      if (p_match && (!hit_q || p_rank_q > hr_q)) begin
        hs_q   <= p_idx_q;
        hr_q   <= p_rank_q;
        hcnt_q <= p_cnt_q;
        hval_q <= p_valid_q;
      end
      if (p_free && (!free_q || p_rank_q < fr_q)) begin
        fs_q <= p_idx_q;
        fr_q <= p_rank_q;
      end
    end
  end

  // decision
  always_comb begin
    wr_addr   = p_idx_q;
    wr_cnt    = 1'b0;
    wr_tag    = 1'b0;
    set_valid = 1'b0;
    touch     = 1'b0;
    cnt_new   = p_cnt_q;
    res_slot  = req_q.slot;
    res_nr    = 1'b0;
    res_st    = STS_OK;
    if (req_q.op == OP_READ) begin
      if (hit_q) begin
        wr_addr  = hs_q;
        res_slot = SLOT_FW'(hs_q);
        if (hcnt_q == COUNT_MAX) begin
          res_st = STS_COUNT_ERR;
        end else begin
          wr_cnt    = 1'b1;
          cnt_new   = hcnt_q + CNT_W'(1);
          set_valid = 1'b1;
          res_nr    = !hval_q;
        end
      end else if (free_q) begin
        wr_addr   = fs_q;
        res_slot  = SLOT_FW'(fs_q);
        wr_tag    = 1'b1;
        wr_cnt    = 1'b1;
        cnt_new   = CNT_W'(1);
        set_valid = 1'b1;
        res_nr    = 1'b1;
      end else begin
        res_slot = '0;
        res_st   = STS_NO_FREE;
      end
    end else if (!slot_ok) begin
      res_st = STS_OK;
    end else if (req_q.op == OP_PIN) begin
      if (p_cnt_q == COUNT_MAX) begin
        res_st = STS_COUNT_ERR;
      end else begin
        wr_cnt  = 1'b1;
        cnt_new = p_cnt_q + CNT_W'(1);
      end
    end else begin
      if (p_free) begin
        res_st = STS_COUNT_ERR;
      end else begin
        wr_cnt  = 1'b1;
        cnt_new = p_cnt_q - CNT_W'(1);
        touch   = (req_q.op == OP_RELEASE) && (p_cnt_q == CNT_W'(1));
      end
    end
    wr_cnt    = wr_cnt    && cmd_i.commit;
    wr_tag    = wr_tag    && cmd_i.commit;
    set_valid = set_valid && cmd_i.commit;
    touch     = touch     && cmd_i.commit;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q.slot_out  <= res_slot;
      out_data_q.need_read <= res_nr;
      out_data_q.status    <= res_st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit while result beat still stalled");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_load_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(cmd_i.search || cmd_i.commit || cmd_i.step))
    else $error("load overlaps other commands");

  a_no_free_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.status == STS_NO_FREE)
      |-> (out_data_q.slot_out == '0 && !out_data_q.need_read))
    else $error("no-free result carries slot or fetch");

  a_fetch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.need_read) |-> (out_data_q.status == STS_OK))
    else $error("fetch flagged on error result");
`endif

endmodule
`default_nettype wire

[design/lru_block_buffer_cache_tags.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_tags
// Tag and LRU policy engine of a block buffer cache with reference counts.
// ----------------------------------------------------------------------------
//  channel   direction   handshake               payload
//  in        input       in_valid_i / in_stall_o   in_data_i  (in_t)
//  out       output      out_valid_o / out_stall_i out_data_o (out_t)
//
//  a read request looks at every slot in turn: the tag memory
//  has one read port and the lookup walks it one slot per cycle
//  release, pin and unpin take one slot read and one commit
//  after reset all slots are free and untagged, no clearing pass
//  a stalled result beat holds in the output register; the next request is
//  taken meanwhile and waits before commit until that beat leaves
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_tags import lbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
